@@ design/pixel_sample_accumulator_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the pixel sample accumulator
// ---------------------------------------------------------------------------
`ifndef PIXEL_SAMPLE_ACCUMULATOR_DEFINES_SVH
`define PIXEL_SAMPLE_ACCUMULATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define PSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/psa_pkg.sv @@
// ---------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the pixel sample accumulator.
// ---------------------------------------------------------------------------
package psa_pkg;

	localparam int MaxPixelsDef = 65536;
	localparam int CountBitsDef = 24;
	localparam int SumW = 40;
	localparam int M1W = 24;
	localparam int M2W = 32;
	localparam int CfgW = 9;
	localparam int DivW = 64;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// request to the shared divider
	typedef struct packed {
		logic            start;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
	} div_req_t;

	// answer of the shared divider
	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quo;
	} div_rsp_t;

endpackage

@@ design/psa_ram.sv @@
// ---------------------------------------------------------------------------
// psa_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module psa_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write or read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ design/psa_div.sv @@
// ---------------------------------------------------------------------------
// psa_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module psa_div import psa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CntW = $clog2(DivW + 1);

	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] quo_q;
	logic [DivW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DivW:0]   trial;

	assign trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};

	// shift in one bit per cycle, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DivW]) begin
				rem_q <= trial[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DivW-2:0], quo_q[DivW-1]};
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

@@ design/pixel_sample_accumulator.sv @@
// ---------------------------------------------------------------------------
// pixel_sample_accumulator
// Per-pixel running mean and luminance variance of XYZ samples.
// ---------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall with cmd, pixel_x/y, sample_x/y/z.
// An add updates the pixel's sums, count and running luma moments and gives
// no output word; a read gives one word on out_valid/out_stall.
// All divisions share one restoring divider. An in-frame add keeps in_stall
// high until its moment updates are written back. An in-frame read runs four
// divisions, the variance and then the three means, and raises out_valid
// when the last one is done; a read of an empty pixel skips the mean
// divisions. Out-of-frame adds are dropped at once; an out-of-frame read
// raises out_valid at the accepting edge. in_stall stays high while a word
// waits in the output register, so out_stall delays the next input and the
// waiting word holds. After reset a clearing pass writes one entry per cycle
// over all MAX_PIXELS entries with in_stall high; configuration writes are
// taken meanwhile. width_q and height_q reset to 256.
// ---------------------------------------------------------------------------
module pixel_sample_accumulator import psa_pkg::*; #(
	parameter int MAX_PIXELS = MaxPixelsDef,
	parameter int COUNT_BITS = CountBitsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            cmd,
	input  logic [7:0]      pixel_x,
	input  logic [7:0]      pixel_y,
	input  logic [15:0]     sample_x,
	input  logic [15:0]     sample_y,
	input  logic [15:0]     sample_z,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [15:0]     mean_x,
	output logic [15:0]     mean_y,
	output logic [15:0]     mean_z,
	output logic [23:0]     sample_count,
	output logic [31:0]     luma_variance,
	output logic            out_of_frame
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = COUNT_BITS;
	localparam int SqW = 2 * M1W;
	localparam int VpW = 32 + CW;
	localparam logic [CW-1:0] CountMax = {CW{1'b1}};
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

	typedef enum logic [12:0] {
		ST_CLEAR = 13'b0000000000001,
		ST_IDLE  = 13'b0000000000010,
		ST_RD    = 13'b0000000000100,
		ST_RD2   = 13'b0000000001000,
		ST_UPD   = 13'b0000000010000,
		ST_DM1   = 13'b0000000100000,
		ST_DM2   = 13'b0000001000000,
		ST_SQ    = 13'b0000010000000,
		ST_VAR   = 13'b0000100000000,
		ST_MNX   = 13'b0001000000000,
		ST_MNY   = 13'b0010000000000,
		ST_MNZ   = 13'b0100000000000,
		ST_OUT   = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [CfgW-1:0] width_q, height_q;
	logic [AW-1:0]   addr_q, clr_q;
	logic            cmd_q;
	logic [15:0]     sx_q, sy_q, sz_q;
	logic            out_valid_q;

	// working registers
	logic [SumW-1:0] sumx_q, sumy_q, sumz_q;
	logic [CW-1:0]   n_q;
	logic [M1W-1:0]  m1_q;
	logic [M2W-1:0]  m2_q;
	logic            neg_q;
	logic [31:0]     vnum_q;
	logic [SqW-1:0]  sq_q;

	// RAM ports
	logic            we;
	logic [AW-1:0]   ram_addr;
	logic [SumW-1:0] wsx, wsy, wsz, rsx, rsy, rsz;
	logic [CW-1:0]   wn, rn;
	logic [M1W-1:0]  wm1, rm1;
	logic [M2W-1:0]  wm2, rm2;

	div_req_t dreq;
	div_rsp_t drsp;

	psa_ram #(.Width(SumW), .Depth(MAX_PIXELS)) u_sx (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wsx), .rdata(rsx));
	psa_ram #(.Width(SumW), .Depth(MAX_PIXELS)) u_sy (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wsy), .rdata(rsy));
	psa_ram #(.Width(SumW), .Depth(MAX_PIXELS)) u_sz (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wsz), .rdata(rsz));
	psa_ram #(.Width(CW), .Depth(MAX_PIXELS)) u_cnt (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wn), .rdata(rn));
	psa_ram #(.Width(M1W), .Depth(MAX_PIXELS)) u_m1 (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wm1), .rdata(rm1));
	psa_ram #(.Width(M2W), .Depth(MAX_PIXELS)) u_m2 (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wm2), .rdata(rm2));

	psa_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// frame check and row-major index
	logic        in_frame;
	logic [16:0] lin;
	assign lin = 17'(pixel_y) * 17'(width_q) + 17'(pixel_x);
	assign in_frame = (9'(pixel_x) < width_q) && (9'(pixel_y) < height_q)
		&& (32'(lin) < 32'(MAX_PIXELS));

	logic accept;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign accept = in_valid && !in_stall;

	// targets of the running moments
	logic [M1W-1:0] t1;
	logic [M2W-1:0] t2;
	assign t1 = {sy_q, 8'h00};
	assign t2 = 32'(sy_q) * 32'(sy_q);

	logic [CW-1:0] n_inc;
	assign n_inc = (rn == CountMax) ? rn : rn + 1'b1;

	logic [SumW:0] ax, ay, az;
	assign ax = {1'b0, rsx} + (SumW+1)'(sx_q);
	assign ay = {1'b0, rsy} + (SumW+1)'(sy_q);
	assign az = {1'b0, rsz} + (SumW+1)'(sz_q);

	assign we = (state_q == ST_CLEAR) || (state_q == ST_DM2 && drsp.done);
	assign ram_addr = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign wsx = (state_q == ST_CLEAR) ? '0 : sumx_q;
	assign wsy = (state_q == ST_CLEAR) ? '0 : sumy_q;
	assign wsz = (state_q == ST_CLEAR) ? '0 : sumz_q;
	assign wn  = (state_q == ST_CLEAR) ? '0 : n_q;

	// apply the signed step to the running means
	logic [M2W-1:0] step2;
	assign step2 = drsp.quo[M2W-1:0];
	assign wm1 = (state_q == ST_CLEAR) ? '0 : m1_q;
	assign wm2 = (state_q == ST_CLEAR) ? '0 : (neg_q ? m2_q - step2 : m2_q + step2);

	// variance numerator: clamp m2<<16 - m1^2 at zero, drop 16 fraction bits
	logic [SqW-1:0] m2s;
	logic [SqW-1:0] dvar;
	assign m2s = {m2_q, 16'h0000};
	assign dvar = m2s - sq_q;

	// Bessel factor n/(n-1), unity for one or no sample
	logic [CW-1:0]  n_mul, n_div;
	logic [VpW-1:0] vprod;
	assign n_mul = (n_q > CW'(1)) ? n_q : CW'(1);
	assign n_div = (n_q > CW'(1)) ? n_q - 1'b1 : CW'(1);
	assign vprod = VpW'(vnum_q) * VpW'(n_mul);

	logic [15:0] qsat;
	assign qsat = (drsp.quo > 64'hFFFF) ? 16'hFFFF : drsp.quo[15:0];

	// divider start requests
	always_comb begin
		dreq = '0;
		case (state_q)
			ST_UPD: begin
				dreq.start = 1'b1;
				dreq.num = (t1 >= m1_q) ? DivW'(t1 - m1_q) : DivW'(m1_q - t1);
				dreq.den = DivW'(n_q);
			end
			ST_DM1: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num = (t2 >= m2_q) ? DivW'(t2 - m2_q) : DivW'(m2_q - t2);
				dreq.den = DivW'(n_q);
			end
			ST_VAR: begin
				dreq.start = 1'b1;
				dreq.num = DivW'(vprod);
				dreq.den = DivW'(n_div);
			end
			ST_MNX: if (drsp.done && n_q != '0) begin
				dreq.start = 1'b1;
				dreq.num = DivW'(sumx_q);
				dreq.den = DivW'(n_q);
			end
			ST_MNY: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num = DivW'(sumy_q);
				dreq.den = DivW'(n_q);
			end
			ST_MNZ: if (drsp.done) begin
				dreq.start = 1'b1;
				dreq.num = DivW'(sumz_q);
				dreq.den = DivW'(n_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			width_q     <= CfgW'(256);
			height_q    <= CfgW'(256);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_PIXELS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (accept) begin
					if (in_frame) begin
						state_q <= ST_RD;
					end else if (cmd == CMD_READ) begin
						out_valid_q <= 1'b1;
					end
				end
				ST_RD:  state_q <= ST_RD2;
				ST_RD2: state_q <= (cmd_q == CMD_ADD) ? ST_UPD : ST_SQ;
				ST_UPD: state_q <= ST_DM1;
				ST_DM1: if (drsp.done) state_q <= ST_DM2;
				ST_DM2: if (drsp.done) state_q <= ST_IDLE;
				ST_SQ:  state_q <= ST_VAR;
				ST_VAR: state_q <= ST_MNX;
				ST_MNX: if (drsp.done) begin
					if (n_q == '0) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= ST_MNY;
					end
				end
				ST_MNY: if (drsp.done) state_q <= ST_MNZ;
				ST_MNZ: if (drsp.done) state_q <= ST_OUT;
				ST_OUT: if (drsp.done) begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers and the output word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				cmd_q  <= cmd;
				addr_q <= AW'(lin);
				sx_q   <= sample_x;
				sy_q   <= sample_y;
				sz_q   <= sample_z;
				if (!in_frame) begin
					mean_x <= '0; mean_y <= '0; mean_z <= '0;
					sample_count <= '0; luma_variance <= '0;
					out_of_frame <= 1'b1;
				end
			end
			ST_RD2: begin
				m1_q <= rm1;
				m2_q <= rm2;
				if (cmd_q == CMD_ADD) begin
					sumx_q <= ax[SumW] ? SumMax : ax[SumW-1:0];
					sumy_q <= ay[SumW] ? SumMax : ay[SumW-1:0];
					sumz_q <= az[SumW] ? SumMax : az[SumW-1:0];
					n_q    <= n_inc;
				end else begin
					sumx_q <= rsx;
					sumy_q <= rsy;
					sumz_q <= rsz;
					n_q    <= rn;
					sq_q   <= SqW'(rm1) * SqW'(rm1);
				end
			end
			ST_UPD: neg_q <= t1 < m1_q;
			ST_DM1: if (drsp.done) begin
				m1_q  <= neg_q ? m1_q - drsp.quo[M1W-1:0] : m1_q + drsp.quo[M1W-1:0];
				neg_q <= t2 < m2_q;
			end
			ST_SQ: vnum_q <= (m2s > sq_q) ? dvar[SqW-1:16] : '0;
			ST_MNX: if (drsp.done) begin
				luma_variance <= (drsp.quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
					: drsp.quo[31:0];
				sample_count <= (32'(n_q) > 32'h00FF_FFFF) ? 24'hFF_FFFF : 24'(n_q);
				out_of_frame <= 1'b0;
				mean_x <= '0; mean_y <= '0; mean_z <= '0;
			end
			ST_MNY: if (drsp.done) mean_x <= qsat;
			ST_MNZ: if (drsp.done) mean_y <= qsat;
			ST_OUT: if (drsp.done) mean_z <= qsat;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/psa_checker.sv @@
// ---------------------------------------------------------------------------
// psa_checker
// Port-level checks of the pixel sample accumulator.
// ---------------------------------------------------------------------------
`include "pixel_sample_accumulator_defines.svh"

module psa_checker import psa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic cmd,
	input logic out_valid,
	input logic out_stall,
	input logic out_of_frame
);

	logic in_acc;
	logic add_acc;
	logic out_held;
	assign in_acc = in_valid && !in_stall;
	assign add_acc = in_acc && (cmd == CMD_ADD);
	assign out_held = out_valid && out_stall;

	// an accepted add never yields a word next cycle
	`PSA_ASSERT_NEXT(a_add_quiet, clk, arst_n, add_acc, !out_valid, "add produced a word")
	// a waiting word keeps the input stalled
	`PSA_ASSERT_IMPL(a_out_blocks, clk, arst_n, out_valid, in_stall, "input open")
	// a stalled word holds its flag
	`PSA_ASSERT_NEXT(a_hold, clk, arst_n, out_held, out_valid && $stable(out_of_frame), "moved")
	// after accepting, a word that comes out keeps the input stalled
	`PSA_ASSERT_NEXT(a_busy, clk, arst_n, in_acc, in_stall || !out_valid, "no stall")

endmodule

bind pixel_sample_accumulator psa_checker u_psa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
	.out_valid(out_valid), .out_stall(out_stall), .out_of_frame(out_of_frame));

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Pixel sample accumulator bench
// Runs a stimulus table, then random add/read traffic over several frame
// sizes and idle and stall patterns. A local model of the pixel stores or a
// table row predicts each read, and the output words are checked in order.
// ---------------------------------------------------------------------------
module testbench;
	import psa_pkg::*;

	localparam int NPIX = 65536;
	localparam int WATCH_LIMIT = 400000;
	localparam int SETTLE = 400;
	localparam int PHASE_WORDS = 218;

	typedef struct {
		logic [15:0] mx;
		logic [15:0] my;
		logic [15:0] mz;
		logic [23:0] cnt;
		logic [31:0] var_q;
		logic        oof;
	} pixel_stats_t;

	typedef struct {
		bit           frame;
		int           fw;
		int           fh;
		logic         op;
		logic [7:0]   px;
		logic [7:0]   py;
		logic [15:0]  sx;
		logic [15:0]  sy;
		logic [15:0]  sz;
		bit           typed;
		pixel_stats_t stats;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_WIDTH;
	logic [8:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = CMD_ADD;
	logic [7:0]  pixel_x = '0;
	logic [7:0]  pixel_y = '0;
	logic [15:0] sample_x = '0;
	logic [15:0] sample_y = '0;
	logic [15:0] sample_z = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] mean_x;
	logic [15:0] mean_y;
	logic [15:0] mean_z;
	logic [23:0] sample_count;
	logic [31:0] luma_variance;
	logic        out_of_frame;

	// model copy of the pixel stores and frame size
	bit [39:0] sum_x_mdl[NPIX];
	bit [39:0] sum_y_mdl[NPIX];
	bit [39:0] sum_z_mdl[NPIX];
	bit [23:0] count_mdl[NPIX];
	bit [23:0] luma_mean_mdl[NPIX];
	bit [31:0] luma_sq_mdl[NPIX];
	int        frame_w = 256;
	int        frame_h = 256;

	pixel_stats_t stats_pending[$];
	int           errors = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           quiet_cycles = 0;
	int           n_adds = 0;
	int           n_reads = 0;
	int           n_oof = 0;
	row_t         rows[$];

	pixel_sample_accumulator dut (.*);

	always #6 clk = ~clk;

	function automatic longint unsigned step_mean(longint unsigned m, longint unsigned t,
			longint unsigned n);
		if (t >= m)
			return m + (t - m) / n;
		return m - (m - t) / n;
	endfunction

	function automatic logic [15:0] avg_of(longint unsigned s, longint unsigned n);
		longint unsigned q;
		if (n == 0)
			return '0;
		q = s / n;
		return (q > 16'hFFFF) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
	endfunction

	// update the stores for one accepted word; return 1 when a read gives stats
	function automatic bit accumulate(logic op, logic [7:0] px, logic [7:0] py,
			logic [15:0] sx, logic [15:0] sy, logic [15:0] sz, output pixel_stats_t st);
		longint unsigned idx, n, m1, m2, sq, v;
		bit in_frame;
		idx = longint'(py) * frame_w + px;
		in_frame = (px < frame_w) && (py < frame_h) && (idx < NPIX);
		st = '{default: '0};
		if (op == CMD_ADD) begin
			if (!in_frame)
				return 0;
			sum_x_mdl[idx] = sat_sum(sum_x_mdl[idx], sx);
			sum_y_mdl[idx] = sat_sum(sum_y_mdl[idx], sy);
			sum_z_mdl[idx] = sat_sum(sum_z_mdl[idx], sz);
			n = count_mdl[idx];
			if (n < 24'hFF_FFFF)
				n++;
			count_mdl[idx] = n;
			luma_mean_mdl[idx] = step_mean(luma_mean_mdl[idx], longint'(sy) << 8, n);
			luma_sq_mdl[idx] = step_mean(luma_sq_mdl[idx], longint'(sy) * sy, n);
			return 0;
		end
		if (!in_frame) begin
			st.oof = 1'b1;
			return 1;
		end
		n = count_mdl[idx];
		m1 = luma_mean_mdl[idx];
		m2 = longint'(luma_sq_mdl[idx]) << 16;
		sq = m1 * m1;
		v = (m2 > sq) ? (m2 - sq) >> 16 : 0;
		if (n > 1)
			v = (v * n) / (n - 1);
		if (v > 32'hFFFF_FFFF)
			v = 32'hFFFF_FFFF;
		st.mx = avg_of(sum_x_mdl[idx], n);
		st.my = avg_of(sum_y_mdl[idx], n);
		st.mz = avg_of(sum_z_mdl[idx], n);
		st.cnt = n;
		st.var_q = v;
		return 1;
	endfunction

	// hold the word until accepted, then predict it
	task automatic send_word(logic op, logic [7:0] px, logic [7:0] py, logic [15:0] sx,
			logic [15:0] sy, logic [15:0] sz, bit typed, pixel_stats_t typed_stats);
		pixel_stats_t st;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		pixel_x <= px;
		pixel_y <= py;
		sample_x <= sx;
		sample_y <= sy;
		sample_z <= sz;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		if (accumulate(op, px, py, sx, sy, sz, st)) begin
			stats_pending.push_back(typed ? typed_stats : st);
			n_reads++;
			if (st.oof)
				n_oof++;
		end else begin
			n_adds++;
		end
	endtask

	// wait for every read to come back, then let a pending add finish
	task automatic drain();
		in_valid <= 1'b0;
		while (stats_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_frame(int w, int h);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w[8:0];
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h[8:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_w = w & 9'h1FF;
		frame_h = h & 9'h1FF;
	endtask

	function automatic row_t word_row(logic op, int px, int py, int sx, int sy, int sz);
		row_t r;
		r = '{default: '0};
		r.op = op;
		r.px = px;
		r.py = py;
		r.sx = sx;
		r.sy = sy;
		r.sz = sz;
		return r;
	endfunction

	function automatic row_t typed_row(logic op, int px, int py, pixel_stats_t st);
		row_t r;
		r = word_row(op, px, py, 0, 0, 0);
		r.typed = 1;
		r.stats = st;
		return r;
	endfunction

	function automatic row_t frame_row(int w, int h);
		row_t r;
		r = '{default: '0};
		r.frame = 1;
		r.fw = w;
		r.fh = h;
		return r;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(3))
			0: return $urandom_range(16'hFFFF);
			1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			2: return 16'h0100 + $urandom_range(16) - 8;
			default: return $urandom_range(16'h03FF);
		endcase
	endfunction

	// check each output word against the oldest prediction
	always @(posedge clk) begin
		pixel_stats_t e;
		if (out_valid && !out_stall) begin
			if (stats_pending.size() == 0) begin
				$error("output word with no read pending");
				errors++;
			end else begin
				e = stats_pending.pop_front();
				if (mean_x !== e.mx) begin
					$error("mean_x exp %h got %h", e.mx, mean_x);
					errors++;
				end
				if (mean_y !== e.my) begin
					$error("mean_y exp %h got %h", e.my, mean_y);
					errors++;
				end
				if (mean_z !== e.mz) begin
					$error("mean_z exp %h got %h", e.mz, mean_z);
					errors++;
				end
				if (sample_count !== e.cnt) begin
					$error("sample_count exp %h got %h", e.cnt, sample_count);
					errors++;
				end
				if (luma_variance !== e.var_q) begin
					$error("luma_variance exp %h got %h", e.var_q, luma_variance);
					errors++;
				end
				if (out_of_frame !== e.oof) begin
					$error("out_of_frame exp %b got %b", e.oof, out_of_frame);
					errors++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// end the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("pixel_sample_accumulator: mismatch");
			$finish;
		end
	end

	initial begin
		int frames_w[8];
		int frames_h[8];
		int w, h, span_x, span_y;
		logic op;
		logic [7:0] px, py;
		pixel_stats_t zero_st, oof_st, full_st, one_st;

		zero_st = '{default: '0};
		oof_st = '{default: '0};
		oof_st.oof = 1'b1;
		full_st = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd1, 32'd0, 1'b0};
		one_st = '{16'h0000, 16'h0000, 16'h0000, 24'd1, 32'd0, 1'b0};

		// stimulus table: corners, extremes, frame edges
		rows.push_back(typed_row(CMD_READ, 0, 0, zero_st));
		rows.push_back(typed_row(CMD_READ, 255, 255, zero_st));
		rows.push_back(word_row(CMD_ADD, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		rows.push_back(typed_row(CMD_READ, 0, 0, full_st));
		rows.push_back(word_row(CMD_ADD, 255, 255, 0, 0, 0));
		rows.push_back(typed_row(CMD_READ, 255, 255, one_st));
		rows.push_back(word_row(CMD_ADD, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		rows.push_back(word_row(CMD_READ, 255, 255, 0, 0, 0));
		rows.push_back(word_row(CMD_ADD, 0, 0, 16'h1234, 16'h0100, 16'hABCD));
		rows.push_back(word_row(CMD_ADD, 0, 0, 16'h8000, 16'h5555, 16'h0001));
		rows.push_back(word_row(CMD_READ, 0, 0, 0, 0, 0));
		rows.push_back(frame_row(200, 100));
		rows.push_back(typed_row(CMD_READ, 200, 0, oof_st));
		rows.push_back(typed_row(CMD_READ, 0, 100, oof_st));
		rows.push_back(word_row(CMD_ADD, 199, 99, 16'h00AA, 16'h7F00, 16'hAA55));
		rows.push_back(word_row(CMD_ADD, 200, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		rows.push_back(word_row(CMD_READ, 199, 99, 0, 0, 0));
		rows.push_back(frame_row(300, 256));
		rows.push_back(typed_row(CMD_READ, 255, 250, oof_st));
		rows.push_back(word_row(CMD_ADD, 255, 250, 1, 2, 3));
		rows.push_back(frame_row(0, 256));
		rows.push_back(typed_row(CMD_READ, 0, 0, oof_st));
		rows.push_back(frame_row(1, 1));
		rows.push_back(word_row(CMD_ADD, 0, 0, 16'h0200, 16'h0300, 16'h0400));
		rows.push_back(word_row(CMD_READ, 0, 0, 0, 0, 0));

		frames_w = '{256, 1, 16, 300, 0, 511, 256, 3};
		frames_h = '{256, 1, 8, 256, 5, 511, 1, 256};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].frame)
				set_frame(rows[i].fw, rows[i].fh);
			else
				send_word(rows[i].op, rows[i].px, rows[i].py, rows[i].sx, rows[i].sy,
					rows[i].sz, rows[i].typed, rows[i].stats);
		end

		// random traffic: one frame size and idle/stall pattern per phase
		for (int ph = 0; ph < 8; ph++) begin
			set_frame(frames_w[ph], frames_h[ph]);
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 66; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 66; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			w = frame_w;
			h = frame_h;
			span_x = (w > 4) ? 4 : w;
			span_y = (h > 3) ? 3 : h;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				op = ($urandom_range(99) < 30) ? CMD_READ : CMD_ADD;
				// mostly a few pixels inside the frame so counts build up
				if ($urandom_range(99) < 75 && span_x > 0 && span_y > 0) begin
					px = $urandom_range(span_x - 1);
					py = $urandom_range(span_y - 1);
					if (w <= 256 && h <= 256 && $urandom_range(3) == 0) begin
						px = w - 1 - px;
						py = h - 1 - py;
					end
				end else begin
					px = $urandom_range(255);
					py = $urandom_range(255);
				end
				send_word(op, px, py, pick_sample(), pick_sample(), pick_sample(), 0,
					zero_st);
			end
		end

		drain();
		$display("covered %0d adds and %0d reads, %0d of them outside the frame,",
			n_adds, n_reads, n_oof);
		$display("over empty, tiny and oversized frames with idle and stall patterns");
		if (errors == 0)
			$display("pixel_sample_accumulator: match");
		else
			$display("pixel_sample_accumulator: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/psa_pkg.sv
design/psa_ram.sv
design/psa_div.sv
design/pixel_sample_accumulator.sv
design/psa_checker.sv
bench/testbench.sv
